@@ src/sbm_pkg.sv @@
// Shared constants and types for the signed add/subtract/multiply unit.
package sbm_pkg;

    // Port width of each operand and of the result
    localparam int DATA_W        = 32;
    localparam int RES_W         = 2 * DATA_W;
    localparam int HALF_W        = DATA_W / 2;
    localparam int WIDTH_DEFAULT = 32;

    // Operation codes
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;

    // Per-stage load enables handed to the multiplier
    typedef struct packed {
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

@@ src/sbm_mul.sv @@
// Two-stage signed multiplier: split partial products, then combine.
module sbm_mul (
    input  logic                                aclk,
    input  sbm_pkg::pipe_en_t                   en,
    input  logic signed [sbm_pkg::DATA_W-1:0]   a,
    input  logic signed [sbm_pkg::DATA_W-1:0]   b,
    output logic signed [sbm_pkg::RES_W-1:0]    product
);

    localparam int HW = sbm_pkg::HALF_W;
    localparam int DW = sbm_pkg::DATA_W;
    localparam int RW = sbm_pkg::RES_W;

    logic signed [DW+HW:0]   pp_lo_reg, pp_lo_next;
    logic signed [DW+HW-1:0] pp_hi_reg, pp_hi_next;
    logic signed [RW-1:0]    product_reg, product_next;

    // Partial products: a times unsigned low half, a times signed high half
    assign pp_lo_next = (DW+HW+1)'(a) * (DW+HW+1)'($signed({1'b0, b[HW-1:0]}));
    assign pp_hi_next = (DW+HW)'(a) * (DW+HW)'($signed(b[DW-1:HW]));

    // Combine: high part weighted by 2^HALF_W
    assign product_next = (RW'(pp_hi_reg) <<< HW) + RW'(pp_lo_reg);

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (en.s3) begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

@@ src/signed_add_sub_booth_mul.sv @@
// Top level: signed add / subtract / multiply unit, three-stage pipeline.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+----------------
//  input   | in        | s_kind, s_operand_a, s_operand_b        | s_valid/s_ready
//  result  | out       | m_value, m_error                        | m_valid/m_ready
//
// Three register stages: an input transfer is loaded into stage 1 and then
// moves through stages 2 and 3, whose registers drive the result port.
// One operation can be taken each cycle unless a full pipe stalls on m_ready.
// Multiply spans stages 2 and 3: registered partial products, then combine.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// A stage takes new data whenever it is empty or its successor moves, so
// bubbles collapse under output stall and no transfer is lost or repeated.
module signed_add_sub_booth_mul #(
    parameter int WIDTH = sbm_pkg::WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic signed [sbm_pkg::DATA_W-1:0]   s_operand_a,
    input  logic signed [sbm_pkg::DATA_W-1:0]   s_operand_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sbm_pkg::RES_W-1:0]    m_value,
    output logic                                m_error
);

    localparam int DW    = sbm_pkg::DATA_W;
    localparam int RW    = sbm_pkg::RES_W;
    localparam int SHIFT = DW - WIDTH;
    // Most negative WIDTH-bit value, sign-extended to the port width
    localparam logic [DW-1:0] MIN_EXT = {DW{1'b1}} << (WIDTH - 1);

    // Stage valid bits and stage advance
    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;
    sbm_pkg::pipe_en_t en;

    // Stage 1 payload
    logic                 mul1_reg;
    logic                 sub1_reg;
    logic signed [DW-1:0] a1_reg, a1_next;
    logic signed [DW-1:0] b1_reg, b1_next;

    // Stage 2 payload
    logic                 mul2_reg;
    logic signed [DW-1:0] sum2_reg, sum2_next;
    logic                 err2_reg, err2_next;

    // Stage 3 payload
    logic                 mul3_reg;
    logic signed [DW-1:0] sum3_reg;
    logic                 err3_reg;
    logic signed [RW-1:0] product;

    // Add/subtract datapath signals
    logic signed [DW-1:0] neg_b;
    logic signed [DW-1:0] nb_ext;
    logic signed [DW-1:0] addend;
    logic signed [DW:0]   sum_full;
    logic signed [DW-1:0] sum_wrap;
    logic                 ovf;
    logic                 neg_err;

    // Handshake chain
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign en.s2   = rdy2;
    assign en.s3   = rdy3;

    assign v1_next = rdy1 ? s_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;
    assign v3_next = rdy3 ? v2_reg  : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: read low WIDTH bits of each operand as two's complement
    assign a1_next = $signed(s_operand_a << SHIFT) >>> SHIFT;
    assign b1_next = $signed(s_operand_b << SHIFT) >>> SHIFT;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            mul1_reg <= s_kind[1];
            sub1_reg <= (s_kind == sbm_pkg::KIND_SUB);
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
        end
    end

    // Stage 2: guarded add; subtract adds the wrapped negation of b
    assign neg_b    = -b1_reg;
    assign nb_ext   = $signed(neg_b << SHIFT) >>> SHIFT;
    assign neg_err  = (b1_reg == MIN_EXT);
    assign addend   = sub1_reg ? nb_ext : b1_reg;
    assign sum_full = {a1_reg[DW-1], a1_reg} + {addend[DW-1], addend};
    assign sum_wrap = $signed(sum_full[DW-1:0] << SHIFT) >>> SHIFT;
    assign ovf      = ({sum_wrap[DW-1], sum_wrap} != sum_full);

    assign sum2_next = sum_wrap;
    // Multiply flags a most negative multiplicand; product itself stays exact
    assign err2_next = mul1_reg ? (a1_reg == MIN_EXT) : (ovf || (sub1_reg && neg_err));

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            mul2_reg <= mul1_reg;
            sum2_reg <= sum2_next;
            err2_reg <= err2_next;
        end
    end

    // Stages 2 and 3 of the multiply
    sbm_mul u_mul (
        .aclk    (aclk),
        .en      (en),
        .a       (a1_reg),
        .b       (b1_reg),
        .product (product)
    );

    // Stage 3: output register
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            mul3_reg <= mul2_reg;
            sum3_reg <= sum2_reg;
            err3_reg <= err2_reg;
        end
    end

    assign m_valid = v3_reg;
    assign m_value = mul3_reg ? product : RW'(sum3_reg);
    assign m_error = err3_reg;

endmodule

@@ dv/signed_add_sub_booth_mul_test.sv @@
// Self-checking testbench for the signed add / subtract / multiply unit.
module signed_add_sub_booth_mul_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = sbm_pkg::DATA_W;
    localparam int RES_W  = sbm_pkg::RES_W;

    // kind 3 is not a named operation but decodes as multiply
    localparam logic [1:0] KIND_MUL_ALT = 2'd3;

    localparam logic signed [DATA_W-1:0] OP_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] OP_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_OPS     = 1300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_LIMIT     = 1000;
    localparam int HOLD_START     = 600;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } alu_op_t;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    error;
    } alu_result_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_kind = sbm_pkg::KIND_ADD;
    logic signed [DATA_W-1:0] s_operand_a = '0;
    logic signed [DATA_W-1:0] s_operand_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [RES_W-1:0] m_value;
    logic m_error;

    alu_op_t     pending_ops[$];
    alu_result_t expected_results[$];

    int ops_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int flagged_results = 0;
    int kind_count[4] = '{0, 0, 0, 0};
    int idle_cycles = 0;
    bit input_backpressured = 1'b0;

    signed_add_sub_booth_mul u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_error     (m_error)
    );

    always #6 aclk = ~aclk;

    // Expected value and overflow flag of one operation
    function automatic alu_result_t alu_predict(logic [1:0] kind,
                                                logic signed [DATA_W-1:0] a,
                                                logic signed [DATA_W-1:0] b);
        alu_result_t r;
        logic signed [DATA_W-1:0] addend;
        logic [DATA_W:0] sum;
        logic neg_ovf;
        if (kind[1]) begin
            // exact signed product; only the multiplicand negation can overflow
            r.value = RES_W'(longint'(a) * longint'(b));
            r.error = (a == OP_MIN);
        end else begin
            neg_ovf = (kind == sbm_pkg::KIND_SUB) && (b == OP_MIN);
            addend  = (kind == sbm_pkg::KIND_SUB) ? -b : b;
            // guard bit is a copy of the sign; disagreement means overflow
            sum     = {a[DATA_W-1], a} + {addend[DATA_W-1], addend};
            r.value = {{(RES_W-DATA_W){sum[DATA_W-1]}}, sum[DATA_W-1:0]};
            r.error = neg_ovf | (sum[DATA_W] != sum[DATA_W-1]);
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 11))
            0: return OP_MIN;
            1: return OP_MAX;
            2: return DATA_W'($signed($urandom_range(0, 2)) - 1);
            3, 4: return DATA_W'($signed($urandom_range(0, 511)) - 256);
            5: return OP_MIN + DATA_W'($urandom_range(0, 3));
            6: return OP_MAX - DATA_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return sbm_pkg::KIND_ADD;
        if (r < 60) return sbm_pkg::KIND_SUB;
        if (r < 90) return sbm_pkg::KIND_MUL;
        return KIND_MUL_ALT;
    endfunction

    task automatic queue_op(logic [1:0] kind, logic signed [DATA_W-1:0] a,
                            logic signed [DATA_W-1:0] b);
        alu_op_t op;
        op.kind = kind;
        op.a    = a;
        op.b    = b;
        pending_ops = {pending_ops, op};
    endtask

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    alu_op_t next_op;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // record the transfer that happened at this edge
            if (s_valid && s_ready) begin
                expected_results = {expected_results,
                                    alu_predict(s_kind, s_operand_a, s_operand_b)};
                ops_sent++;
                kind_count[s_kind]++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    next_op = pending_ops.pop_front();
                    s_valid     <= 1'b1;
                    s_kind      <= next_op.kind;
                    s_operand_a <= next_op.a;
                    s_operand_b <= next_op.b;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern redrawn at random from four modes, plus one long hold-off
    int rx_cycle = 0;
    int hold_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                if (s_valid && !s_ready)
                    input_backpressured = 1'b1;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    alu_result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result value=%h error=%b",
                             $realtime, m_value, m_error);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.error)
                    flagged_results++;
                if (m_value !== want.value || m_error !== want.error) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result %0d: value exp %h got %h, error exp %b got %b",
                                 $realtime, results_checked, want.value, m_value,
                                 want.error, m_error);
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        // directed: range extremes, overflow and negation corners, all kinds
        queue_op(sbm_pkg::KIND_ADD, OP_MAX, OP_MAX);
        queue_op(sbm_pkg::KIND_ADD, OP_MIN, OP_MIN);
        queue_op(sbm_pkg::KIND_ADD, OP_MIN, -1);
        queue_op(sbm_pkg::KIND_ADD, OP_MAX, 1);
        queue_op(sbm_pkg::KIND_ADD, 0, 0);
        queue_op(sbm_pkg::KIND_ADD, -1, 1);
        queue_op(sbm_pkg::KIND_ADD, OP_MAX, OP_MIN);
        queue_op(sbm_pkg::KIND_SUB, 0, OP_MIN);
        queue_op(sbm_pkg::KIND_SUB, OP_MIN, OP_MIN);
        queue_op(sbm_pkg::KIND_SUB, -1, OP_MIN);
        queue_op(sbm_pkg::KIND_SUB, OP_MAX, -1);
        queue_op(sbm_pkg::KIND_SUB, OP_MIN, 1);
        queue_op(sbm_pkg::KIND_SUB, 5, 7);
        queue_op(sbm_pkg::KIND_MUL, OP_MIN, OP_MIN);
        queue_op(sbm_pkg::KIND_MUL, OP_MIN, 1);
        queue_op(sbm_pkg::KIND_MUL, OP_MAX, OP_MAX);
        queue_op(sbm_pkg::KIND_MUL, OP_MAX, OP_MIN);
        queue_op(sbm_pkg::KIND_MUL, -1, -1);
        queue_op(sbm_pkg::KIND_MUL, 0, OP_MIN);
        queue_op(sbm_pkg::KIND_MUL, 123, -456);
        queue_op(KIND_MUL_ALT, OP_MIN, -1);
        queue_op(KIND_MUL_ALT, -7, 9);
        queue_op(KIND_MUL_ALT, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int i = 0; i < RANDOM_OPS; i++)
            queue_op(pick_kind(), pick_operand(), pick_operand());

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d operations sent (add %0d, sub %0d, mul %0d, kind 3 %0d); %0d flagged",
                 ops_sent, kind_count[sbm_pkg::KIND_ADD],
                 kind_count[sbm_pkg::KIND_SUB], kind_count[sbm_pkg::KIND_MUL],
                 kind_count[KIND_MUL_ALT], flagged_results);
        $display("%0d results checked, %0d mismatches, input stalled by full pipe: %0d",
                 results_checked, mismatches, input_backpressured);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
